// File: hw/rtl/mqttp_pkg.sv
package mqttp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 28;

  // Event codes on event_res.
  localparam logic [3:0] EV_NONE     = 4'd0;
  localparam logic [3:0] EV_HDR_DONE = 4'd1;
  localparam logic [3:0] EV_VERSION  = 4'd2;
  localparam logic [3:0] EV_CFLAGS   = 4'd3;
  localparam logic [3:0] EV_KEEPALV  = 4'd4;
  localparam logic [3:0] EV_MSG_ID   = 4'd5;
  localparam logic [3:0] EV_CA_FLAGS = 4'd6;
  localparam logic [3:0] EV_RET_CODE = 4'd7;
  localparam logic [3:0] EV_SA_QOS   = 4'd8;
  localparam logic [3:0] EV_STR_BYTE = 4'd9;
  localparam logic [3:0] EV_ERROR    = 4'd10;

  // Error codes on error_code.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_LEN  = 2'd1;
  localparam logic [1:0] ERR_BAD_TYPE = 2'd2;

  // Control packet types.
  localparam logic [3:0] T_CONNECT = 4'd1;
  localparam logic [3:0] T_CONNACK = 4'd2;
  localparam logic [3:0] T_PUBLISH = 4'd3;
  localparam logic [3:0] T_PUBREC  = 4'd5;
  localparam logic [3:0] T_PUBREL  = 4'd6;
  localparam logic [3:0] T_PUBCOMP = 4'd7;
  localparam logic [3:0] T_SUBACK  = 4'd9;

  // String field identifiers.
  localparam logic [2:0] SF_PROTO   = 3'd0;
  localparam logic [2:0] SF_CLIENT  = 3'd1;
  localparam logic [2:0] SF_WILL_T  = 3'd2;
  localparam logic [2:0] SF_WILL_M  = 3'd3;
  localparam logic [2:0] SF_USER    = 3'd4;
  localparam logic [2:0] SF_PASS    = 3'd5;
  localparam logic [2:0] SF_TOPIC   = 3'd6;
  localparam logic [2:0] SF_PAYLOAD = 3'd7;

  typedef struct packed {
    logic [3:0]      event_res;
    logic [3:0]      message_type;
    logic [15:0]     value;
    logic [LenW-1:0] pkt_length;
    logic [2:0]      string_field;
    logic [LenW-1:0] string_length;
    logic            string_last;
    logic            packet_done;
    logic [1:0]      error_code;
  } result_t;

endpackage

// File: hw/rtl/mqttp_if.sv
interface mqttp_in_if import mqttp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface mqttp_out_if import mqttp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [3:0]      event_res;
  logic [3:0]      message_type;
  logic [15:0]     value;
  logic [LenW-1:0] pkt_length;
  logic [2:0]      string_field;
  logic [LenW-1:0] string_length;
  logic            string_last;
  logic            packet_done;
  logic [1:0]      error_code;

  modport source (
    output valid, output event_res, output message_type, output value,
    output pkt_length, output string_field, output string_length,
    output string_last, output packet_done, output error_code, input ready
  );
  modport sink (
    input valid, input event_res, input message_type, input value,
    input pkt_length, input string_field, input string_length,
    input string_last, input packet_done, input error_code, output ready
  );
endinterface

// File: hw/rtl/mqttp_parse.sv
module mqttp_parse import mqttp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] data_byte_i,
  output result_t          res_o
);

  typedef enum logic [14:0] {
    PH_HDR      = 15'h0001,
    PH_LEN      = 15'h0002,
    PH_STR_HI   = 15'h0004,
    PH_STR_LO   = 15'h0008,
    PH_STR_BODY = 15'h0010,
    PH_VERSION  = 15'h0020,
    PH_CFLAGS   = 15'h0040,
    PH_KA_HI    = 15'h0080,
    PH_KA_LO    = 15'h0100,
    PH_ID_HI    = 15'h0200,
    PH_ID_LO    = 15'h0400,
    PH_CA_FLAGS = 15'h0800,
    PH_CA_CODE  = 15'h1000,
    PH_SA_QOS   = 15'h2000,
    PH_PAYLOAD  = 15'h4000
  } phase_e;

  typedef struct packed {
    phase_e          phase;
    logic [2:0]      cur_str;
    logic [LenW-1:0] decl_len;
    logic [LenW-1:0] field_rem;
    logic            done;
  } next_t;

  phase_e          phase_q, phase_d;
  logic [7:0]      header_q, header_d;
  logic [LenW-1:0] len_acc_q, len_acc_d;
  logic [2:0]      len_cnt_q, len_cnt_d;
  logic [LenW-1:0] vbs_q, vbs_d;
  logic [LenW-1:0] field_rem_q, field_rem_d;
  logic [7:0]      cflags_q, cflags_d;
  logic [2:0]      cur_str_q, cur_str_d;
  logic [7:0]      hold_q, hold_d;
  logic [LenW-1:0] decl_len_q, decl_len_d;

  logic [3:0]      ev;
  logic [15:0]     val;
  logic            slast;
  logic            done;
  logic [1:0]      err;
  logic            in_str;
  logic [LenW-1:0] digit_sh;
  logic [LenW-1:0] str_len;
  logic [LenW-1:0] rem_dec;
  next_t           nx;

  // Payload start: the payload runs for what the remaining length leaves after
  // the variable header; an empty payload finishes the packet at once.
  function automatic next_t start_payload(input logic [LenW-1:0] acc,
                                          input logic [LenW-1:0] seen,
                                          input next_t           base);
    next_t           r;
    logic [LenW-1:0] len;
    r   = base;
    len = (acc > seen) ? (acc - seen) : '0;
    r.done = 1'b0;
    if (len == '0) begin
      r.phase = PH_HDR;
      r.done  = 1'b1;
    end else begin
      r.cur_str   = SF_PAYLOAD;
      r.decl_len  = len;
      r.field_rem = len;
      r.phase     = PH_PAYLOAD;
    end
    return r;
  endfunction

  function automatic next_t start_str(input logic [2:0] k, input next_t base);
    next_t r;
    r          = base;
    r.cur_str  = k;
    r.decl_len = '0;
    r.phase    = PH_STR_HI;
    r.done     = 1'b0;
    return r;
  endfunction

  // Picks the field that follows a finished string.
  function automatic next_t after_str(input logic [2:0]      k,
                                      input logic [7:0]      flags,
                                      input logic [7:0]      hdr,
                                      input logic [LenW-1:0] acc,
                                      input logic [LenW-1:0] seen,
                                      input next_t           base);
    next_t r;
    logic  will, user, pass;
    r    = base;
    will = flags[2];
    pass = flags[6];
    user = flags[7];
    r.done = 1'b0;
    if (k == SF_PROTO) begin
      r.phase = PH_VERSION;
    end else if (k == SF_TOPIC) begin
      if (hdr[2:1] != 2'd0) begin
        r.phase = PH_ID_HI;
      end else begin
        r = start_payload(acc, seen, base);
      end
    end else if (k == SF_CLIENT && will) begin
      r = start_str(SF_WILL_T, base);
    end else if (k == SF_WILL_T) begin
      r = start_str(SF_WILL_M, base);
    end else if ((k == SF_CLIENT || k == SF_WILL_M) && user) begin
      r = start_str(SF_USER, base);
    end else if ((k == SF_CLIENT || k == SF_WILL_M || k == SF_USER) && pass) begin
      r = start_str(SF_PASS, base);
    end else begin
      r.phase = PH_HDR;
      r.done  = 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    phase_d     = phase_q;
    header_d    = header_q;
    len_acc_d   = len_acc_q;
    len_cnt_d   = len_cnt_q;
    vbs_d       = vbs_q;
    field_rem_d = field_rem_q;
    cflags_d    = cflags_q;
    cur_str_d   = cur_str_q;
    hold_d      = hold_q;
    decl_len_d  = decl_len_q;
    ev          = EV_NONE;
    val         = {8'd0, data_byte_i};
    slast       = 1'b0;
    done        = 1'b0;
    err         = ERR_NONE;
    in_str      = 1'b0;
    nx          = '{phase: phase_q, cur_str: cur_str_q, decl_len: decl_len_q,
                    field_rem: field_rem_q, done: 1'b0};
    str_len     = {{(LenW-16){1'b0}}, hold_q, data_byte_i};
    rem_dec     = (field_rem_q != '0) ? (field_rem_q - 1'b1) : '0;

    // Each length byte carries seven bits, least significant group first.
    case (len_cnt_q[1:0])
      2'd0:    digit_sh = {21'd0, data_byte_i[6:0]};
      2'd1:    digit_sh = {14'd0, data_byte_i[6:0], 7'd0};
      2'd2:    digit_sh = {7'd0, data_byte_i[6:0], 14'd0};
      default: digit_sh = {data_byte_i[6:0], 21'd0};
    endcase

    if (!(phase_q inside {PH_HDR, PH_LEN})) begin
      vbs_d = vbs_q + 1'b1;
    end

    case (phase_q)
      PH_HDR: begin
        header_d    = data_byte_i;
        len_acc_d   = '0;
        len_cnt_d   = '0;
        vbs_d       = '0;
        field_rem_d = '0;
        cur_str_d   = SF_PROTO;
        decl_len_d  = '0;
        phase_d     = PH_LEN;
      end
      PH_LEN: begin
        len_acc_d = len_acc_q + digit_sh;
        len_cnt_d = len_cnt_q + 1'b1;
        if (data_byte_i[7]) begin
          if (len_cnt_d >= 3'd4) begin
            ev      = EV_ERROR;
            err     = ERR_BAD_LEN;
            phase_d = PH_HDR;
          end
        end else begin
          val = {8'd0, header_q};
          ev  = EV_HDR_DONE;
          case (header_q[7:4])
            T_CONNECT: begin
              cur_str_d  = SF_PROTO;
              decl_len_d = '0;
              phase_d    = PH_STR_HI;
            end
            T_PUBLISH: begin
              cur_str_d  = SF_TOPIC;
              decl_len_d = '0;
              phase_d    = PH_STR_HI;
            end
            T_CONNACK: phase_d = PH_CA_FLAGS;
            T_PUBREC, T_PUBREL, T_PUBCOMP, T_SUBACK: phase_d = PH_ID_HI;
            default: begin
              ev      = EV_ERROR;
              err     = ERR_BAD_TYPE;
              val     = {8'd0, data_byte_i};
              phase_d = PH_HDR;
            end
          endcase
        end
      end
      PH_STR_HI: begin
        in_str  = 1'b1;
        hold_d  = data_byte_i;
        phase_d = PH_STR_LO;
      end
      PH_STR_LO: begin
        in_str      = 1'b1;
        decl_len_d  = str_len;
        field_rem_d = str_len;
        if (str_len == '0) begin
          slast = 1'b1;
          nx = after_str(cur_str_q, cflags_q, header_q, len_acc_q, vbs_d,
                         '{phase: phase_q, cur_str: cur_str_q, decl_len: str_len,
                           field_rem: str_len, done: 1'b0});
          phase_d     = nx.phase;
          cur_str_d   = nx.cur_str;
          decl_len_d  = nx.decl_len;
          field_rem_d = nx.field_rem;
          done        = nx.done;
        end else begin
          phase_d = PH_STR_BODY;
        end
      end
      PH_STR_BODY, PH_PAYLOAD: begin
        in_str      = 1'b1;
        ev          = EV_STR_BYTE;
        field_rem_d = rem_dec;
        if (rem_dec == '0) begin
          slast = 1'b1;
          if (phase_q == PH_PAYLOAD) begin
            phase_d = PH_HDR;
            done    = 1'b1;
          end else begin
            nx = after_str(cur_str_q, cflags_q, header_q, len_acc_q, vbs_d,
                           '{phase: phase_q, cur_str: cur_str_q, decl_len: decl_len_q,
                             field_rem: rem_dec, done: 1'b0});
            phase_d     = nx.phase;
            cur_str_d   = nx.cur_str;
            decl_len_d  = nx.decl_len;
            field_rem_d = nx.field_rem;
            done        = nx.done;
          end
        end
      end
      PH_VERSION: begin
        ev      = EV_VERSION;
        phase_d = PH_CFLAGS;
      end
      PH_CFLAGS: begin
        ev       = EV_CFLAGS;
        cflags_d = data_byte_i;
        phase_d  = PH_KA_HI;
      end
      PH_KA_HI: begin
        hold_d  = data_byte_i;
        phase_d = PH_KA_LO;
      end
      PH_KA_LO: begin
        ev         = EV_KEEPALV;
        val        = {hold_q, data_byte_i};
        cur_str_d  = SF_CLIENT;
        decl_len_d = '0;
        phase_d    = PH_STR_HI;
      end
      PH_ID_HI: begin
        hold_d  = data_byte_i;
        phase_d = PH_ID_LO;
      end
      PH_ID_LO: begin
        ev  = EV_MSG_ID;
        val = {hold_q, data_byte_i};
        if (header_q[7:4] == T_PUBLISH) begin
          nx = start_payload(len_acc_q, vbs_d,
                             '{phase: phase_q, cur_str: cur_str_q, decl_len: decl_len_q,
                               field_rem: field_rem_q, done: 1'b0});
          phase_d     = nx.phase;
          cur_str_d   = nx.cur_str;
          decl_len_d  = nx.decl_len;
          field_rem_d = nx.field_rem;
          done        = nx.done;
        end else if (header_q[7:4] == T_SUBACK) begin
          phase_d = PH_SA_QOS;
        end else begin
          phase_d = PH_HDR;
          done    = 1'b1;
        end
      end
      PH_CA_FLAGS: begin
        ev      = EV_CA_FLAGS;
        phase_d = PH_CA_CODE;
      end
      PH_CA_CODE: begin
        ev      = EV_RET_CODE;
        phase_d = PH_HDR;
        done    = 1'b1;
      end
      PH_SA_QOS: begin
        ev      = EV_SA_QOS;
        phase_d = PH_HDR;
        done    = 1'b1;
      end
      default: begin
        phase_d = PH_HDR;
      end
    endcase

    res_o.event_res     = ev;
    res_o.message_type  = header_d[7:4];
    res_o.value         = val;
    res_o.pkt_length    = len_acc_d;
    res_o.string_field  = in_str ? cur_str_d : 3'd0;
    res_o.string_length = in_str ? decl_len_d : '0;
    res_o.string_last   = slast;
    res_o.packet_done   = done;
    res_o.error_code    = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HDR;
      header_q    <= '0;
      len_acc_q   <= '0;
      len_cnt_q   <= '0;
      vbs_q       <= '0;
      field_rem_q <= '0;
      cflags_q    <= '0;
      cur_str_q   <= '0;
      hold_q      <= '0;
      decl_len_q  <= '0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      header_q    <= header_d;
      len_acc_q   <= len_acc_d;
      len_cnt_q   <= len_cnt_d;
      vbs_q       <= vbs_d;
      field_rem_q <= field_rem_d;
      cflags_q    <= cflags_d;
      cur_str_q   <= cur_str_d;
      hold_q      <= hold_d;
      decl_len_q  <= decl_len_d;
    end
  end

endmodule

// File: hw/rtl/mqttp_out_stage.sv
module mqttp_out_stage import mqttp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  result_t res_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // The register takes a new word when it is empty or its word leaves now.
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// File: hw/rtl/mqtt_packet_byte_parser_core.sv
// Channel  | Dir | Payload            | Meaning
// ---------+-----+--------------------+---------------------------------------
// in_i     | in  | data_byte          | one stream byte per word
// out_o    | out | event_res .. error | one parse result word per input byte
//
// One byte is taken every cycle while in_i.ready is high; its result word
// appears next cycle from the output register. The parser state updates
// in the same cycle the byte is taken, so the next byte may follow directly.
// in_i.ready is high while the output register is empty or being read; a
// stall on out_o with a word in the register drops in_i.ready in that cycle.
// Reset puts the parser in wait for a fixed header and empties the register.
module mqtt_packet_byte_parser_core import mqttp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  mqttp_in_if.sink    in_i,
  mqttp_out_if.source out_o
);

  logic    accept;
  logic    in_ready;
  result_t step_res;
  result_t out_res;

  assign accept     = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  mqttp_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .data_byte_i(in_i.data_byte),
    .res_o      (step_res)
  );

  mqttp_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .res_i      (step_res),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .res_o      (out_res)
  );

  assign out_o.event_res     = out_res.event_res;
  assign out_o.message_type  = out_res.message_type;
  assign out_o.value         = out_res.value;
  assign out_o.pkt_length    = out_res.pkt_length;
  assign out_o.string_field  = out_res.string_field;
  assign out_o.string_length = out_res.string_length;
  assign out_o.string_last   = out_res.string_last;
  assign out_o.packet_done   = out_res.packet_done;
  assign out_o.error_code    = out_res.error_code;

endmodule

// File: hw/rtl/mqttp_checker.sv
module mqttp_checker import mqttp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [3:0]  event_res_i,
  input logic [15:0] value_i,
  input logic [1:0]  error_code_i,
  input logic        string_last_i,
  input logic        packet_done_i
);

  // A held word must not change while the sink stalls.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> ($stable(value_i) && $stable(event_res_i)))
    else $error("result word changed under stall");

  // Every taken byte yields a word in the next cycle.
  a_word_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> out_valid_i)
    else $error("no result after accepted byte");

  // An empty output register never blocks the input.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output register");

  // The error event and an error code always come together.
  a_err_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((event_res_i == EV_ERROR) == (error_code_i != ERR_NONE)))
    else $error("error event and error code disagree");

  // An error word neither ends a string nor completes a packet.
  a_err_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (error_code_i != ERR_NONE)) |-> (!string_last_i && !packet_done_i))
    else $error("error word flagged as string end or packet end");

endmodule

bind mqtt_packet_byte_parser_core mqttp_checker u_mqttp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .event_res_i  (out_o.event_res),
  .value_i      (out_o.value),
  .error_code_i (out_o.error_code),
  .string_last_i(out_o.string_last),
  .packet_done_i(out_o.packet_done)
);

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import mqttp_pkg::*;

  typedef enum logic [4:0] {
    PS_HDR, PS_LEN, PS_STR_HI, PS_STR_LO, PS_STR_BODY, PS_VERSION, PS_CFLAGS,
    PS_KA_HI, PS_KA_LO, PS_ID_HI, PS_ID_LO, PS_CA_FLAGS, PS_CA_CODE, PS_SA_QOS,
    PS_PAYLOAD
  } parse_phase_e;

  typedef struct packed {
    parse_phase_e    phase;
    logic [7:0]      hdr;
    logic [LenW-1:0] rem_len;
    logic [2:0]      digits;
    logic [LenW-1:0] body_cnt;
    logic [LenW-1:0] field_left;
    logic [7:0]      cflags;
    logic [2:0]      field_id;
    logic [7:0]      hold;
    logic [LenW-1:0] decl_len;
  } parser_st_t;

  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    result_t    want;
  } stim_t;

  localparam int unsigned RandomBytes = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic go = 1'b0;

  mqttp_in_if  in_if ();
  mqttp_out_if out_if ();

  mqtt_packet_byte_parser_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  parser_st_t  parser_now;    // follows the bytes as the block accepts them
  parser_st_t  parser_ahead;  // follows the bytes as they are generated
  stim_t       byte_stream[$];
  result_t     pending_words[$];
  logic [7:0]  pkt_q[$];
  logic [7:0]  body_q[$];
  stim_t       cur_byte;
  int unsigned accepted = 0;
  int unsigned total = 0;
  int unsigned fails = 0;
  int          in_gap = 0;
  int          in_calm = 0;
  int          out_stall = 0;
  int          out_calm = 0;

  // ---------------------------------------------------------------------------
  // Parser prediction
  // ---------------------------------------------------------------------------

  function automatic void open_string(inout parser_st_t s, input logic [2:0] id);
    s.field_id = id;
    s.decl_len = '0;
    s.phase    = PS_STR_HI;
  endfunction

  // Returns 1 when the PUBLISH has no payload left and is therefore complete.
  function automatic logic open_payload(inout parser_st_t s);
    logic [LenW-1:0] n;
    n = (s.rem_len > s.body_cnt) ? s.rem_len - s.body_cnt : '0;
    if (n == 0) begin
      s.phase = PS_HDR;
      return 1'b1;
    end
    s.field_id   = SF_PAYLOAD;
    s.decl_len   = n;
    s.field_left = n;
    s.phase      = PS_PAYLOAD;
    return 1'b0;
  endfunction

  function automatic logic next_field(inout parser_st_t s);
    logic [2:0] k;
    logic will, user, pass;
    k    = s.field_id;
    will = s.cflags[2];
    user = s.cflags[7];
    pass = s.cflags[6];
    if (k == SF_PROTO) begin
      s.phase = PS_VERSION;
      return 1'b0;
    end
    if (k == SF_TOPIC) begin
      if (s.hdr[2:1] != 2'd0) begin
        s.phase = PS_ID_HI;
        return 1'b0;
      end
      return open_payload(s);
    end
    if (k == SF_CLIENT && will) begin
      open_string(s, SF_WILL_T);
      return 1'b0;
    end
    if (k == SF_WILL_T) begin
      open_string(s, SF_WILL_M);
      return 1'b0;
    end
    if ((k == SF_CLIENT || k == SF_WILL_M) && user) begin
      open_string(s, SF_USER);
      return 1'b0;
    end
    if ((k == SF_CLIENT || k == SF_WILL_M || k == SF_USER) && pass) begin
      open_string(s, SF_PASS);
      return 1'b0;
    end
    s.phase = PS_HDR;
    return 1'b1;
  endfunction

  function automatic result_t parse_next_byte(inout parser_st_t s, input logic [7:0] b);
    result_t         r;
    logic            in_str;
    logic [LenW-1:0] add;
    r       = '0;
    r.value = {8'h00, b};
    in_str  = 1'b0;
    if (s.phase != PS_HDR && s.phase != PS_LEN) s.body_cnt = s.body_cnt + 1'b1;
    case (s.phase)
      PS_HDR: begin
        s.hdr        = b;
        s.rem_len    = '0;
        s.digits     = '0;
        s.body_cnt   = '0;
        s.field_left = '0;
        s.field_id   = '0;
        s.decl_len   = '0;
        s.phase      = PS_LEN;
      end
      PS_LEN: begin
        add       = {21'd0, b[6:0]} << (7 * s.digits[1:0]);
        s.rem_len = s.rem_len + add;
        s.digits  = s.digits + 1'b1;
        if (b[7]) begin
          if (s.digits >= 3'd4) begin
            r.event_res  = EV_ERROR;
            r.error_code = ERR_BAD_LEN;
            s.phase      = PS_HDR;
          end
        end else begin
          r.value     = {8'h00, s.hdr};
          r.event_res = EV_HDR_DONE;
          case (s.hdr[7:4])
            T_CONNECT: open_string(s, SF_PROTO);
            T_PUBLISH: open_string(s, SF_TOPIC);
            T_CONNACK: s.phase = PS_CA_FLAGS;
            T_PUBREC, T_PUBREL, T_PUBCOMP, T_SUBACK: s.phase = PS_ID_HI;
            default: begin
              r.event_res  = EV_ERROR;
              r.error_code = ERR_BAD_TYPE;
              r.value      = {8'h00, b};
              s.phase      = PS_HDR;
            end
          endcase
        end
      end
      PS_STR_HI: begin
        in_str  = 1'b1;
        s.hold  = b;
        s.phase = PS_STR_LO;
      end
      PS_STR_LO: begin
        in_str       = 1'b1;
        s.decl_len   = {12'd0, s.hold, b};
        s.field_left = s.decl_len;
        if (s.decl_len == 0) begin
          r.string_last = 1'b1;
          r.packet_done = next_field(s);
        end else begin
          s.phase = PS_STR_BODY;
        end
      end
      PS_STR_BODY, PS_PAYLOAD: begin
        in_str      = 1'b1;
        r.event_res = EV_STR_BYTE;
        if (s.field_left != 0) s.field_left = s.field_left - 1'b1;
        if (s.field_left == 0) begin
          r.string_last = 1'b1;
          if (s.phase == PS_PAYLOAD) begin
            s.phase       = PS_HDR;
            r.packet_done = 1'b1;
          end else begin
            r.packet_done = next_field(s);
          end
        end
      end
      PS_VERSION: begin
        r.event_res = EV_VERSION;
        s.phase     = PS_CFLAGS;
      end
      PS_CFLAGS: begin
        r.event_res = EV_CFLAGS;
        s.cflags    = b;
        s.phase     = PS_KA_HI;
      end
      PS_KA_HI: begin
        s.hold  = b;
        s.phase = PS_KA_LO;
      end
      PS_KA_LO: begin
        r.event_res = EV_KEEPALV;
        r.value     = {s.hold, b};
        open_string(s, SF_CLIENT);
      end
      PS_ID_HI: begin
        s.hold  = b;
        s.phase = PS_ID_LO;
      end
      PS_ID_LO: begin
        r.event_res = EV_MSG_ID;
        r.value     = {s.hold, b};
        if (s.hdr[7:4] == T_PUBLISH) begin
          r.packet_done = open_payload(s);
        end else if (s.hdr[7:4] == T_SUBACK) begin
          s.phase = PS_SA_QOS;
        end else begin
          s.phase       = PS_HDR;
          r.packet_done = 1'b1;
        end
      end
      PS_CA_FLAGS: begin
        r.event_res = EV_CA_FLAGS;
        s.phase     = PS_CA_CODE;
      end
      PS_CA_CODE: begin
        r.event_res   = EV_RET_CODE;
        s.phase       = PS_HDR;
        r.packet_done = 1'b1;
      end
      PS_SA_QOS: begin
        r.event_res   = EV_SA_QOS;
        s.phase       = PS_HDR;
        r.packet_done = 1'b1;
      end
      default: s.phase = PS_HDR;
    endcase
    // String outputs show the state after the byte, so a finished string that
    // opens the next one reports the new field.
    r.message_type = s.hdr[7:4];
    r.pkt_length   = s.rem_len;
    if (in_str) begin
      r.string_field  = s.field_id;
      r.string_length = s.decl_len;
    end
    return r;
  endfunction

  function automatic parser_st_t idle_parser();
    parser_st_t s;
    s       = '0;
    s.phase = PS_HDR;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic stim_t row(input logic [7:0] d);
    stim_t it;
    it      = '0;
    it.data = d;
    return it;
  endfunction

  function automatic stim_t row_want(input logic [7:0] d, input logic [3:0] ev,
                                     input logic [3:0] ty, input logic [15:0] v,
                                     input logic [LenW-1:0] rl, input logic [2:0] sf,
                                     input logic [LenW-1:0] sl, input logic last,
                                     input logic done, input logic [1:0] err);
    stim_t it;
    it                    = row(d);
    it.typed              = 1'b1;
    it.want.event_res     = ev;
    it.want.message_type  = ty;
    it.want.value         = v;
    it.want.pkt_length    = rl;
    it.want.string_field  = sf;
    it.want.string_length = sl;
    it.want.string_last   = last;
    it.want.packet_done   = done;
    it.want.error_code    = err;
    return it;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  task automatic send_row(input stim_t it);
    result_t dummy;
    dummy = parse_next_byte(parser_ahead, it.data);
    byte_stream.push_back(it);
  endtask

  // Noise is kept from opening huge strings or payloads, which would only
  // stretch the run without reaching anything new.
  function automatic logic [7:0] tame_byte(input parser_st_t s, input logic [7:0] b);
    if (s.phase == PS_STR_HI) return {7'd0, b[0]};
    if (s.phase == PS_LEN && s.hdr[7:4] == T_PUBLISH && s.digits != 0) return {7'd0, b[0]};
    return b;
  endfunction

  task automatic put_varint(input int unsigned v);
    logic [7:0] d;
    do begin
      d = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0) d[7] = 1'b1;
      pkt_q.push_back(d);
    end while (v != 0);
  endtask

  function automatic int unsigned pick_str_len();
    int unsigned r;
    r = $urandom_range(0, 31);
    if (r == 0) return $urandom_range(256, 300);
    if (r < 6) return 0;
    return $urandom_range(1, 8);
  endfunction

  task automatic put_str(input int unsigned n);
    body_q.push_back(n[15:8]);
    body_q.push_back(n[7:0]);
    repeat (n) body_q.push_back(rand_byte());
  endtask

  task automatic put_rand(input int unsigned n);
    repeat (n) body_q.push_back(rand_byte());
  endtask

  // The parser ignores the remaining length outside PUBLISH, so it is
  // sometimes any value at all.
  function automatic int unsigned loose_rem(input int unsigned len);
    case ($urandom_range(0, 7))
      0: return $urandom & 32'h0FFF_FFFF;
      1: return 32'h0FFF_FFFF;
      2: return $urandom_range(0, 200);
      default: return len;
    endcase
  endfunction

  task automatic make_packet();
    logic [7:0]  hdr;
    logic [7:0]  flags;
    logic [3:0]  ty;
    int unsigned kind, rem, hp, n;
    body_q.delete();
    pkt_q.delete();
    hdr  = rand_byte();
    kind = $urandom_range(0, 12);
    rem  = 0;
    if (kind <= 2) begin
      hdr[7:4] = T_CONNECT;
      put_str(pick_str_len());
      put_rand(1);
      flags = rand_byte();
      body_q.push_back(flags);
      put_rand(2);
      put_str(pick_str_len());
      if (flags[2]) begin
        put_str(pick_str_len());
        put_str(pick_str_len());
      end
      if (flags[7]) put_str(pick_str_len());
      if (flags[6]) put_str(pick_str_len());
      rem = loose_rem(body_q.size());
    end else if (kind == 3) begin
      hdr[7:4] = T_CONNACK;
      put_rand(2);
      rem = loose_rem(2);
    end else if (kind <= 7) begin
      hdr[7:4] = T_PUBLISH;
      put_str(pick_str_len());
      if (hdr[2:1] != 2'd0) put_rand(2);
      hp = body_q.size();
      case ($urandom_range(0, 15))
        0: n = $urandom_range(100, 200);
        1, 2: n = 0;
        default: n = $urandom_range(1, 12);
      endcase
      rem = hp + n;
      if ($urandom_range(0, 7) == 0) begin
        rem = $urandom_range(0, hp);
        n   = 0;
      end
      put_rand(n);
    end else if (kind <= 9) begin
      case ($urandom_range(0, 2))
        0: hdr[7:4] = T_PUBREC;
        1: hdr[7:4] = T_PUBREL;
        default: hdr[7:4] = T_PUBCOMP;
      endcase
      put_rand(2);
      rem = loose_rem(2);
    end else if (kind == 10) begin
      hdr[7:4] = T_SUBACK;
      put_rand(3);
      rem = loose_rem(3);
    end else if (kind == 11) begin
      ty = 4'($urandom_range(0, 15));
      while (ty == T_CONNECT || ty == T_CONNACK || ty == T_PUBLISH || ty == T_PUBREC ||
             ty == T_PUBREL || ty == T_PUBCOMP || ty == T_SUBACK)
        ty = 4'($urandom_range(0, 15));
      hdr[7:4] = ty;
      rem = loose_rem($urandom_range(0, 127));
    end else begin
      // A continuation bit on all four length bytes.
      pkt_q.push_back(hdr);
      repeat (4) pkt_q.push_back(rand_byte() | 8'h80);
      return;
    end
    pkt_q.push_back(hdr);
    put_varint(rem);
    foreach (body_q[i]) pkt_q.push_back(body_q[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Handshakes and checking
  // ---------------------------------------------------------------------------

  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 150);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic take_byte(input stim_t it);
    result_t p;
    p = parse_next_byte(parser_now, it.data);
    pending_words.push_back(it.typed ? it.want : p);
    accepted++;
  endtask

  function automatic int unsigned cmp_field(input string name, input logic [LenW-1:0] want,
                                            input logic [LenW-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  function automatic result_t sample_out();
    result_t w;
    w.event_res     = out_if.event_res;
    w.message_type  = out_if.message_type;
    w.value         = out_if.value;
    w.pkt_length    = out_if.pkt_length;
    w.string_field  = out_if.string_field;
    w.string_length = out_if.string_length;
    w.string_last   = out_if.string_last;
    w.packet_done   = out_if.packet_done;
    w.error_code    = out_if.error_code;
    return w;
  endfunction

  task automatic check_word(input result_t got);
    result_t want;
    if (pending_words.size() == 0) begin
      $error("result word with no byte pending, event_res 0x%0h", got.event_res);
      fails++;
    end else begin
      want = pending_words.pop_front();
      fails += cmp_field("event_res", LenW'(want.event_res), LenW'(got.event_res))
             + cmp_field("message_type", LenW'(want.message_type), LenW'(got.message_type))
             + cmp_field("value", LenW'(want.value), LenW'(got.value))
             + cmp_field("pkt_length", want.pkt_length, got.pkt_length)
             + cmp_field("string_field", LenW'(want.string_field), LenW'(got.string_field))
             + cmp_field("string_length", want.string_length, got.string_length)
             + cmp_field("string_last", LenW'(want.string_last), LenW'(got.string_last))
             + cmp_field("packet_done", LenW'(want.packet_done), LenW'(got.packet_done))
             + cmp_field("error_code", LenW'(want.error_code), LenW'(got.error_code));
    end
  endtask

  always @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) take_byte(cur_byte);
    if (!in_if.valid || in_if.ready) begin
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (go && byte_stream.size() != 0) begin
        cur_byte = byte_stream.pop_front();
        in_if.valid     <= 1'b1;
        in_if.data_byte <= cur_byte.data;
        in_gap = idle_len(in_calm);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) check_word(sample_out());
    if (out_stall > 0) begin
      out_stall--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      out_stall = idle_len(out_calm);
    end
  end

  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin : main
    stim_t       dir_rows[$];
    int unsigned r, cut;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    out_if.ready    = 1'b0;
    parser_now      = idle_parser();
    parser_ahead    = idle_parser();

    // Length continued on all four bytes, right after reset.
    dir_rows.push_back(row_want(8'hF0, EV_NONE, 4'hF, 16'h00F0, '0, '0, '0, 1'b0, 1'b0,
                                ERR_NONE));
    dir_rows.push_back(row(8'hFF));
    dir_rows.push_back(row(8'hFF));
    dir_rows.push_back(row(8'hFF));
    dir_rows.push_back(row_want(8'hFF, EV_ERROR, 4'hF, 16'h00FF, 28'hFFF_FFFF, '0, '0, 1'b0,
                                1'b0, ERR_BAD_LEN));
    // Unknown type with the largest remaining length.
    dir_rows.push_back(row(8'h00));
    dir_rows.push_back(row(8'hFF));
    dir_rows.push_back(row(8'hFF));
    dir_rows.push_back(row(8'hFF));
    dir_rows.push_back(row_want(8'h7F, EV_ERROR, 4'h0, 16'h007F, 28'hFFF_FFFF, '0, '0, 1'b0,
                                1'b0, ERR_BAD_TYPE));
    // PUBLISH with an empty topic and no payload: done on the topic length.
    dir_rows.push_back(row(8'h30));
    dir_rows.push_back(row(8'h02));
    dir_rows.push_back(row(8'h00));
    dir_rows.push_back(row_want(8'h00, EV_NONE, T_PUBLISH, 16'h0000, 28'd2, SF_TOPIC, '0,
                                1'b1, 1'b1, ERR_NONE));
    // SUBACK whose remaining length of zero is ignored.
    dir_rows.push_back(row(8'h90));
    dir_rows.push_back(row(8'h00));
    dir_rows.push_back(row(8'hFF));
    dir_rows.push_back(row_want(8'hFF, EV_MSG_ID, T_SUBACK, 16'hFFFF, '0, '0, '0, 1'b0, 1'b0,
                                ERR_NONE));
    dir_rows.push_back(row(8'h80));
    // CONNACK.
    dir_rows.push_back(row(8'h20));
    dir_rows.push_back(row(8'h02));
    dir_rows.push_back(row(8'h00));
    dir_rows.push_back(row(8'hFF));
    foreach (dir_rows[i]) send_row(dir_rows[i]);

    while (byte_stream.size() < dir_rows.size() + RandomBytes) begin
      r = $urandom_range(0, 19);
      make_packet();
      if (r < 15) begin
        foreach (pkt_q[i]) send_row(row(pkt_q[i]));
      end else if (r < 17) begin
        cut = $urandom_range(1, pkt_q.size() - 1);
        for (int i = 0; i < cut; i++) send_row(row(pkt_q[i]));
      end else begin
        repeat ($urandom_range(1, 6)) send_row(row(tame_byte(parser_ahead, rand_byte())));
      end
      // Bring the parser back to a packet boundary before the next packet.
      while (parser_ahead.phase != PS_HDR)
        send_row(row(tame_byte(parser_ahead, rand_byte())));
    end
    total = byte_stream.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    go <= 1'b1;

    while (accepted != total) @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (fails == 0 && pending_words.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/mqttp_pkg.sv
hw/rtl/mqttp_if.sv
hw/rtl/mqttp_parse.sv
hw/rtl/mqttp_out_stage.sv
hw/rtl/mqtt_packet_byte_parser_core.sv
hw/rtl/mqttp_checker.sv
tb/tb.sv
